// File: rtl/grid_adjacent_pair_rect_count_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacent free pair counter
// Shared shorthands for clocked concurrent checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef GRID_ADJACENT_PAIR_RECT_COUNT_DEFINES_SVH
`define GRID_ADJACENT_PAIR_RECT_COUNT_DEFINES_SVH

// Check a property on every rising edge of clk_i outside reset
`define GAPRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define GAPRC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/gaprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaprc_pkg
// Sizes, codes and types shared by the adjacent free pair counter.
// ----------------------------------------------------------------------------
package gaprc_pkg;

  // Grid capacity
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // Index and storage widths
  localparam int RA_W      = $clog2(MAX_ROWS);
  localparam int CA_W      = $clog2(MAX_COLS);
  localparam int ADDR_W    = RA_W + CA_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int ROWP_W    = $clog2(MAX_COLS);
  localparam int COLP_W    = $clog2(MAX_ROWS);
  localparam int COLW_W    = 1 + COLP_W;

  // Field widths of the transactions and registers
  localparam int FIELD_W = 6;
  localparam int GRID_W  = 7;
  localparam int COUNT_W = 13;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes (word select bit of paddr)
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Transaction modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WR,
    S_Q_RUN,
    S_Q_DRAIN,
    S_DONE
  } state_e;

  // Register file to sequencer
  typedef struct packed {
    logic [GRID_W-1:0] grid_rows;
    logic [GRID_W-1:0] grid_cols;
    logic              wr;
  } cfg_t;

  // Column store word: cell bit and vertical pair count
  typedef struct packed {
    logic              free;
    logic [COLP_W-1:0] cnt;
  } col_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ROWP_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } row_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    col_word_t         wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } col_req_t;

endpackage

// File: rtl/gaprc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaprc_in_if / gaprc_out_if
// Valid/ready channels for cell and query transactions and for results.
// ----------------------------------------------------------------------------
interface gaprc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic                               cell_free;
  logic [gaprc_pkg::FIELD_W-1:0]      top_row;
  logic [gaprc_pkg::FIELD_W-1:0]      left_col;
  logic [gaprc_pkg::FIELD_W-1:0]      bottom_row;
  logic [gaprc_pkg::FIELD_W-1:0]      right_col;

  modport source (
    output valid, mode, cell_free, top_row, left_col, bottom_row, right_col,
    input  ready
  );
  modport sink (
    input  valid, mode, cell_free, top_row, left_col, bottom_row, right_col,
    output ready
  );
endinterface

interface gaprc_out_if;
  logic                               valid;
  logic                               ready;
  logic [gaprc_pkg::COUNT_W-1:0]      pair_count;
  logic                               bad_query;

  modport source (
    output valid, pair_count, bad_query,
    input  ready
  );
  modport sink (
    input  valid, pair_count, bad_query,
    output ready
  );
endinterface

// File: rtl/gaprc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaprc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gaprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read; the read data is registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/gaprc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaprc_cfg
// APB register file for the grid size; a write also flags a load restart.
// ----------------------------------------------------------------------------
module gaprc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gaprc_pkg::APB_AW-1:0]     paddr,
  input  logic [gaprc_pkg::APB_DW-1:0]     pwdata,
  output logic [gaprc_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  output gaprc_pkg::cfg_t                  cfg_o
);

  logic [gaprc_pkg::GRID_W-1:0] grid_rows_q, grid_rows_d;
  logic [gaprc_pkg::GRID_W-1:0] grid_cols_q, grid_cols_d;
  logic                         wr_en;
  logic                         reg_sel;
  logic [gaprc_pkg::GRID_W-1:0] wval;
  logic [gaprc_pkg::GRID_W-1:0] rows_clamped;
  logic [gaprc_pkg::GRID_W-1:0] cols_clamped;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[gaprc_pkg::APB_AW-1];
  assign wval    = pwdata[gaprc_pkg::GRID_W-1:0];

  // Clamp a written size into 1..max
  always_comb begin
    rows_clamped = wval;
    if (wval == '0) begin
      rows_clamped = gaprc_pkg::GRID_W'(1);
    end else if (wval > gaprc_pkg::GRID_W'(gaprc_pkg::MAX_ROWS)) begin
      rows_clamped = gaprc_pkg::GRID_W'(gaprc_pkg::MAX_ROWS);
    end
    cols_clamped = wval;
    if (wval == '0) begin
      cols_clamped = gaprc_pkg::GRID_W'(1);
    end else if (wval > gaprc_pkg::GRID_W'(gaprc_pkg::MAX_COLS)) begin
      cols_clamped = gaprc_pkg::GRID_W'(gaprc_pkg::MAX_COLS);
    end
  end

  // Decode the write
  always_comb begin
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    if (wr_en) begin
      case (reg_sel)
        gaprc_pkg::REG_GRID_ROWS: grid_rows_d = rows_clamped;
        gaprc_pkg::REG_GRID_COLS: grid_cols_d = cols_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= gaprc_pkg::GRID_W'(gaprc_pkg::MAX_ROWS);
      grid_cols_q <= gaprc_pkg::GRID_W'(gaprc_pkg::MAX_COLS);
    end else begin
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      gaprc_pkg::REG_GRID_ROWS: prdata = gaprc_pkg::APB_DW'(grid_rows_q);
      gaprc_pkg::REG_GRID_COLS: prdata = gaprc_pkg::APB_DW'(grid_cols_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.grid_rows = grid_rows_q;
  assign cfg_o.grid_cols = grid_cols_q;
  assign cfg_o.wr        = wr_en;

endmodule

// File: rtl/gaprc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaprc_ctrl
// Sequencer and datapath: read-modify-write of the prefix stores on a load,
// a parallel walk of rows and columns on a query, and the result register.
// ----------------------------------------------------------------------------
`include "grid_adjacent_pair_rect_count_defines.svh"

module gaprc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gaprc_pkg::cfg_t                   cfg_i,
  gaprc_in_if.sink                          in_i,
  gaprc_out_if.source                       out_o,
  output gaprc_pkg::row_req_t               row_req_o,
  output gaprc_pkg::col_req_t               col_req_o,
  input  logic [gaprc_pkg::ROWP_W-1:0]      row_rd_a_i,
  input  logic [gaprc_pkg::ROWP_W-1:0]      row_rd_b_i,
  input  gaprc_pkg::col_word_t              col_rd_a_i,
  input  gaprc_pkg::col_word_t              col_rd_b_i
);

  gaprc_pkg::state_e state_q, state_d;

  // Load position and running row count
  logic [gaprc_pkg::RA_W-1:0]   load_row_q, load_row_d;
  logic [gaprc_pkg::CA_W-1:0]   load_col_q, load_col_d;
  logic [gaprc_pkg::ROWP_W-1:0] row_run_q, row_run_d;
  logic                         prev_free_q, prev_free_d;

  // Query walk
  logic [gaprc_pkg::RA_W-1:0]   top_q, bottom_q;
  logic [gaprc_pkg::CA_W-1:0]   left_q, right_q;
  logic [gaprc_pkg::RA_W:0]     ri_q, ri_d;
  logic [gaprc_pkg::CA_W:0]     ci_q, ci_d;
  logic                         v_row_q, v_row_d;
  logic                         v_col_q, v_col_d;
  logic [gaprc_pkg::COUNT_W-1:0] acc_q, acc_d;
  logic                         bad_q;
  logic                         free_q;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [gaprc_pkg::COUNT_W-1:0] out_count_q;
  logic                          out_bad_q;
  logic                          out_load;

  logic                          in_acc;
  logic                          is_query;
  logic                          q_bad;
  logic                          walk_last;
  logic                          row_active;
  logic                          col_active;
  logic [gaprc_pkg::RA_W-1:0]    above_row;
  logic [gaprc_pkg::ROWP_W-1:0]  row_new;
  logic [gaprc_pkg::COLP_W-1:0]  col_new;
  logic [gaprc_pkg::COUNT_W-1:0] row_diff;
  logic [gaprc_pkg::COUNT_W-1:0] col_diff;

  assign in_i.ready = (state_q == gaprc_pkg::S_IDLE);
  assign in_acc     = in_i.valid && (state_q == gaprc_pkg::S_IDLE);
  assign is_query   = (in_i.mode == gaprc_pkg::MODE_QUERY);
  assign out_load   = (state_q == gaprc_pkg::S_DONE) && (!out_valid_q || out_o.ready);

  // Reject reversed corners and corners outside the grid
  assign q_bad = (in_i.top_row > in_i.bottom_row) || (in_i.left_col > in_i.right_col)
              || (gaprc_pkg::GRID_W'(in_i.bottom_row) >= cfg_i.grid_rows)
              || (gaprc_pkg::GRID_W'(in_i.right_col) >= cfg_i.grid_cols);

  assign row_active = (ri_q <= {1'b0, bottom_q});
  assign col_active = (ci_q <= {1'b0, right_q});
  assign walk_last  = (ri_q >= {1'b0, bottom_q}) && (ci_q >= {1'b0, right_q});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gaprc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!is_query) begin
            state_d = gaprc_pkg::S_LD_WR;
          end else if (q_bad) begin
            state_d = gaprc_pkg::S_DONE;
          end else begin
            state_d = gaprc_pkg::S_Q_RUN;
          end
        end
      end
      gaprc_pkg::S_LD_WR:   state_d = gaprc_pkg::S_IDLE;
      gaprc_pkg::S_Q_RUN: begin
        if (walk_last) begin
          state_d = gaprc_pkg::S_Q_DRAIN;
        end
      end
      gaprc_pkg::S_Q_DRAIN: state_d = gaprc_pkg::S_DONE;
      gaprc_pkg::S_DONE: begin
        if (out_load) begin
          state_d = gaprc_pkg::S_IDLE;
        end
      end
      default:              state_d = gaprc_pkg::S_IDLE;
    endcase
  end

  // New prefix values of the cell being loaded
  assign above_row = load_row_q - gaprc_pkg::RA_W'(1);
  assign row_new = (load_col_q == '0) ? '0
                 : row_run_q + gaprc_pkg::ROWP_W'(free_q && prev_free_q);
  assign col_new = (load_row_q == '0) ? '0
                 : col_rd_a_i.cnt + gaprc_pkg::COLP_W'(free_q && col_rd_a_i.free);

  // Per-step differences, taken modulo the count width
  assign row_diff = gaprc_pkg::COUNT_W'(row_rd_a_i) - gaprc_pkg::COUNT_W'(row_rd_b_i);
  assign col_diff = gaprc_pkg::COUNT_W'(col_rd_a_i.cnt) - gaprc_pkg::COUNT_W'(col_rd_b_i.cnt);

  // Memory requests and datapath updates
  always_comb begin
    row_req_o         = '0;
    col_req_o         = '0;
    load_row_d        = load_row_q;
    load_col_d        = load_col_q;
    row_run_d         = row_run_q;
    prev_free_d       = prev_free_q;
    ri_d              = ri_q;
    ci_d              = ci_q;
    v_row_d           = 1'b0;
    v_col_d           = 1'b0;
    acc_d             = acc_q + (v_row_q ? row_diff : '0) + (v_col_q ? col_diff : '0);
    out_valid_d       = out_valid_q;

    // Walk addresses: row ends of row ri, column ends of column ci
    row_req_o.raddr_a = {ri_q[gaprc_pkg::RA_W-1:0], right_q};
    row_req_o.raddr_b = {ri_q[gaprc_pkg::RA_W-1:0], left_q};
    col_req_o.raddr_a = {bottom_q, ci_q[gaprc_pkg::CA_W-1:0]};
    col_req_o.raddr_b = {top_q, ci_q[gaprc_pkg::CA_W-1:0]};

    case (state_q)
      gaprc_pkg::S_IDLE: begin
        // Fetch the cell above the load position
        col_req_o.raddr_a = {above_row, load_col_q};
        if (in_acc && is_query) begin
          ri_d  = {1'b0, gaprc_pkg::RA_W'(in_i.top_row)};
          ci_d  = {1'b0, gaprc_pkg::CA_W'(in_i.left_col)};
          acc_d = '0;
        end
      end
      gaprc_pkg::S_LD_WR: begin
        row_req_o.we    = 1'b1;
        row_req_o.waddr = {load_row_q, load_col_q};
        row_req_o.wdata = row_new;
        col_req_o.we    = 1'b1;
        col_req_o.waddr = {load_row_q, load_col_q};
        col_req_o.wdata = '{free: free_q, cnt: col_new};
        row_run_d       = row_new;
        prev_free_d     = free_q;
        // Advance in raster order, wrap at the grid end
        if ((gaprc_pkg::GRID_W'(load_col_q) + gaprc_pkg::GRID_W'(1)) >= cfg_i.grid_cols) begin
          load_col_d = '0;
          if ((gaprc_pkg::GRID_W'(load_row_q) + gaprc_pkg::GRID_W'(1)) >= cfg_i.grid_rows) begin
            load_row_d = '0;
          end else begin
            load_row_d = load_row_q + gaprc_pkg::RA_W'(1);
          end
        end else begin
          load_col_d = load_col_q + gaprc_pkg::CA_W'(1);
        end
      end
      gaprc_pkg::S_Q_RUN: begin
        v_row_d = row_active;
        v_col_d = col_active;
        ri_d    = ri_q + (gaprc_pkg::RA_W + 1)'(1);
        ci_d    = ci_q + (gaprc_pkg::CA_W + 1)'(1);
      end
      gaprc_pkg::S_Q_DRAIN: ;
      gaprc_pkg::S_DONE: ;
      default: ;
    endcase

    // Restart loading on any register write
    if (cfg_i.wr) begin
      load_row_d = '0;
      load_col_d = '0;
      row_run_d  = '0;
    end

    // Result slot
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gaprc_pkg::S_IDLE;
      load_row_q  <= '0;
      load_col_q  <= '0;
      row_run_q   <= '0;
      prev_free_q <= 1'b0;
      v_row_q     <= 1'b0;
      v_col_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      row_run_q   <= row_run_d;
      prev_free_q <= prev_free_d;
      v_row_q     <= v_row_d;
      v_col_q     <= v_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ri_q  <= ri_d;
    ci_q  <= ci_d;
    acc_q <= acc_d;
    if (in_acc) begin
      free_q   <= in_i.cell_free;
      top_q    <= gaprc_pkg::RA_W'(in_i.top_row);
      bottom_q <= gaprc_pkg::RA_W'(in_i.bottom_row);
      left_q   <= gaprc_pkg::CA_W'(in_i.left_col);
      right_q  <= gaprc_pkg::CA_W'(in_i.right_col);
      bad_q    <= q_bad;
    end
    if (out_load) begin
      out_count_q <= bad_q ? '0 : acc_q;
      out_bad_q   <= bad_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pair_count = out_count_q;
  assign out_o.bad_query  = out_bad_q;

  // Checks
  `GAPRC_ASSERT(a_load_pos_in_grid,
    (gaprc_pkg::GRID_W'(load_col_q) < cfg_i.grid_cols)
      && (gaprc_pkg::GRID_W'(load_row_q) < cfg_i.grid_rows),
    "load position outside the configured grid")
  `GAPRC_ASSERT(a_done_posts_result,
    out_load |=> out_valid_q,
    "finished query did not post its result")
  `GAPRC_ASSERT_IMPL(a_acc_follows_walk, v_row_q || v_col_q,
    $past(state_q) == gaprc_pkg::S_Q_RUN,
    "accumulate flag set outside a query walk")
  `GAPRC_ASSERT_IMPL(a_bad_has_zero_count, out_valid_q && out_bad_q,
    out_count_q == '0,
    "rejected query carries a nonzero count")

endmodule

// File: rtl/grid_adjacent_pair_rect_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_adjacent_pair_rect_count
// A load transaction stores the next grid cell in raster order: it first
// reads the cell above from the column store, then writes the
// new row and column pair counts. A query transaction returns the number of
// horizontally and vertically adjacent free pairs inside an inclusive
// rectangle, set in the result register by a walk that reads both ends of
// one row from the row store and both ends of one column from the column
// store each cycle over their two read ports. Loads are accepted while a
// result waits to be taken. Bad corners give count 0 with the error flag.
// A register write restarts loading at row 0, col 0.
// ----------------------------------------------------------------------------
module grid_adjacent_pair_rect_count (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gaprc_pkg::APB_AW-1:0] paddr,
  input  logic [gaprc_pkg::APB_DW-1:0] pwdata,
  output logic [gaprc_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  gaprc_in_if.sink                     in_i,
  gaprc_out_if.source                  out_o
);

  gaprc_pkg::cfg_t                cfg;
  gaprc_pkg::row_req_t            row_req;
  gaprc_pkg::col_req_t            col_req;
  logic [gaprc_pkg::ROWP_W-1:0]   row_rd_a;
  logic [gaprc_pkg::ROWP_W-1:0]   row_rd_b;
  gaprc_pkg::col_word_t           col_rd_a;
  gaprc_pkg::col_word_t           col_rd_b;

  // Size registers
  gaprc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Horizontal pair prefix store
  gaprc_ram #(
    .WIDTH (gaprc_pkg::ROWP_W),
    .DEPTH (gaprc_pkg::MEM_DEPTH)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (row_req.we),
    .waddr_i   (row_req.waddr),
    .wdata_i   (row_req.wdata),
    .raddr_a_i (row_req.raddr_a),
    .raddr_b_i (row_req.raddr_b),
    .rdata_a_o (row_rd_a),
    .rdata_b_o (row_rd_b)
  );

  // Cell bit and vertical pair prefix store
  gaprc_ram #(
    .WIDTH (gaprc_pkg::COLW_W),
    .DEPTH (gaprc_pkg::MEM_DEPTH)
  ) u_col_ram (
    .clk_i     (clk_i),
    .we_i      (col_req.we),
    .waddr_i   (col_req.waddr),
    .wdata_i   (col_req.wdata),
    .raddr_a_i (col_req.raddr_a),
    .raddr_b_i (col_req.raddr_b),
    .rdata_a_o (col_rd_a),
    .rdata_b_o (col_rd_b)
  );

  // Sequencer and datapath
  gaprc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_i       (in_i),
    .out_o      (out_o),
    .row_req_o  (row_req),
    .col_req_o  (col_req),
    .row_rd_a_i (row_rd_a),
    .row_rd_b_i (row_rd_b),
    .col_rd_a_i (col_rd_a),
    .col_rd_b_i (col_rd_b)
  );

endmodule

// File: sim/tb_grid_adjacent_pair_rect_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_adjacent_pair_rect_count
// Loads binary grids of several shapes through the cell channel and fires
// rectangle queries at them. A local copy of the grid, the per-row and
// per-column pair counts and the load position predicts every query result.
// Results are checked in order against the predictions. Both channels idle at
// random, and the grid size registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_grid_adjacent_pair_rect_count;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RESET_CYCLES   = 12;
  localparam int REPORT_MAX     = 10;
  localparam int SWAP_AT        = 600;
  localparam int CALM_AT        = 1200;
  localparam int SEND_IDLE_PCT  = 35;
  localparam int TAKE_IDLE_PCT  = 46;

  typedef struct {
    logic                          mode;
    logic                          cell_free;
    logic [gaprc_pkg::FIELD_W-1:0] top_row;
    logic [gaprc_pkg::FIELD_W-1:0] left_col;
    logic [gaprc_pkg::FIELD_W-1:0] bottom_row;
    logic [gaprc_pkg::FIELD_W-1:0] right_col;
  } grid_op_t;

  typedef struct {
    logic [gaprc_pkg::COUNT_W-1:0] pair_count;
    logic                          bad_query;
  } pair_result_t;

  logic                         clk_i   = 1'b0;
  logic                         rst_ni  = 1'b0;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [gaprc_pkg::APB_AW-1:0] paddr   = '0;
  logic [gaprc_pkg::APB_DW-1:0] pwdata  = '0;
  logic [gaprc_pkg::APB_DW-1:0] prdata;
  logic                         pready;

  gaprc_in_if  op_if ();
  gaprc_out_if res_if ();

  grid_adjacent_pair_rect_count dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (op_if),
    .out_o   (res_if)
  );

  // Clock
  always #5 clk_i = ~clk_i;

  // Pending transactions and awaited query results
  grid_op_t     grid_ops_q[$];
  pair_result_t awaited_counts[$];

  // Predicted grid contents and pair counts
  logic cell_m [gaprc_pkg::MAX_ROWS][gaprc_pkg::MAX_COLS];
  logic [gaprc_pkg::ROWP_W-1:0] row_pairs_m [gaprc_pkg::MAX_ROWS][gaprc_pkg::MAX_COLS];
  logic [gaprc_pkg::COLP_W-1:0] col_pairs_m [gaprc_pkg::MAX_ROWS][gaprc_pkg::MAX_COLS];
  int unsigned       ld_row, ld_col, run_pairs, rows_m, cols_m;

  // Generator view: which entries hold data, where the next load lands
  bit                written_g [gaprc_pkg::MAX_ROWS][gaprc_pkg::MAX_COLS];
  int unsigned       gen_row, gen_col, gen_rows, gen_cols;

  int unsigned       ops_taken;
  int unsigned       results_seen;
  int unsigned       err_cnt;
  int unsigned       quiet_cycles;
  grid_op_t          next_op;
  grid_op_t          seen_op;
  pair_result_t      want;

  function automatic int unsigned clamp_dim(logic [gaprc_pkg::GRID_W-1:0] v,
                                            int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Store one cell and update the running row and column pair counts
  function automatic void predict_load(logic free);
    int unsigned                  r;
    int unsigned                  c;
    logic [gaprc_pkg::COLP_W-1:0] above;
    r = ld_row;
    c = ld_col;
    cell_m[r][c] = free;
    if (c == 0) begin
      run_pairs = 0;
    end else if (free && cell_m[r][c-1]) begin
      run_pairs++;
    end
    row_pairs_m[r][c] = gaprc_pkg::ROWP_W'(run_pairs);
    if (r == 0) begin
      above = '0;
    end else begin
      above = col_pairs_m[r-1][c];
      if (free && cell_m[r-1][c]) above++;
    end
    col_pairs_m[r][c] = above;
    ld_col++;
    if (ld_col >= cols_m) begin
      ld_col = 0;
      ld_row++;
      if (ld_row >= rows_m) ld_row = 0;
    end
  endfunction

  // Sum row and column count differences over the rectangle
  function automatic pair_result_t predict_query(grid_op_t op);
    pair_result_t res;
    int           sum;
    int unsigned  t, l, b, r;
    t = op.top_row;
    l = op.left_col;
    b = op.bottom_row;
    r = op.right_col;
    res.pair_count = '0;
    res.bad_query  = 1'b0;
    if (t > b || l > r || b >= rows_m || r >= cols_m) begin
      res.bad_query = 1'b1;
      return res;
    end
    sum = 0;
    for (int unsigned i = t; i <= b; i++)
      sum += int'(row_pairs_m[i][r]) - int'(row_pairs_m[i][l]);
    for (int unsigned i = l; i <= r; i++)
      sum += int'(col_pairs_m[b][i]) - int'(col_pairs_m[t][i]);
    res.pair_count = sum[gaprc_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic int unsigned send_idle_pct();
    if (ops_taken < SWAP_AT) return SEND_IDLE_PCT;
    if (ops_taken < CALM_AT) return TAKE_IDLE_PCT;
    return 0;
  endfunction

  function automatic int unsigned take_idle_pct();
    if (ops_taken < SWAP_AT) return TAKE_IDLE_PCT;
    if (ops_taken < CALM_AT) return SEND_IDLE_PCT;
    return 0;
  endfunction

  // True when every prefix entry the query reads has been loaded at some point
  function automatic bit rect_written(int unsigned t, l, b, r);
    for (int unsigned i = t; i <= b; i++)
      if (!written_g[i][l] || !written_g[i][r]) return 1'b0;
    for (int unsigned i = l; i <= r; i++)
      if (!written_g[t][i] || !written_g[b][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit corners_bad(int unsigned t, l, b, r);
    return t > b || l > r || b >= gen_rows || r >= gen_cols;
  endfunction

  task automatic note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("ERROR: %s", msg);
  endtask

  task automatic push_load(input logic free);
    grid_op_t op;
    op.mode       = gaprc_pkg::MODE_LOAD;
    op.cell_free  = free;
    op.top_row    = gaprc_pkg::FIELD_W'($urandom);
    op.left_col   = gaprc_pkg::FIELD_W'($urandom);
    op.bottom_row = gaprc_pkg::FIELD_W'($urandom);
    op.right_col  = gaprc_pkg::FIELD_W'($urandom);
    grid_ops_q = {grid_ops_q, op};
    written_g[gen_row][gen_col] = 1'b1;
    gen_col++;
    if (gen_col >= gen_cols) begin
      gen_col = 0;
      gen_row++;
      if (gen_row >= gen_rows) gen_row = 0;
    end
  endtask

  task automatic push_query(input int unsigned t, l, b, r);
    grid_op_t op;
    op.mode       = gaprc_pkg::MODE_QUERY;
    op.cell_free  = 1'($urandom);
    op.top_row    = gaprc_pkg::FIELD_W'(t);
    op.left_col   = gaprc_pkg::FIELD_W'(l);
    op.bottom_row = gaprc_pkg::FIELD_W'(b);
    op.right_col  = gaprc_pkg::FIELD_W'(r);
    grid_ops_q = {grid_ops_q, op};
  endtask

  // Reversed corners or corners beyond the grid
  task automatic push_bad_query();
    int unsigned t, l, b, r, kind;
    t    = $urandom_range(63);
    l    = $urandom_range(63);
    b    = $urandom_range(63);
    r    = $urandom_range(63);
    kind = $urandom_range(3);
    if (kind == 2 && gen_rows < gaprc_pkg::MAX_ROWS) begin
      b = $urandom_range(63, gen_rows);
      t = $urandom_range(b);
    end else if (kind == 3 && gen_cols < gaprc_pkg::MAX_COLS) begin
      r = $urandom_range(63, gen_cols);
      l = $urandom_range(r);
    end else if (kind[0]) begin
      l = $urandom_range(63, 1);
      r = $urandom_range(l - 1);
    end else begin
      t = $urandom_range(63, 1);
      b = $urandom_range(t - 1);
    end
    push_query(t, l, b, r);
  endtask

  task automatic push_random_query();
    int unsigned t, l, b, r, roll;
    int          tries;
    bit          done;
    done = 1'b0;
    roll = $urandom_range(99);
    if (roll < 15) begin
      push_bad_query();
    end else if (roll < 25) begin
      // Raw noise on all corners
      t = $urandom_range(63);
      l = $urandom_range(63);
      b = $urandom_range(63);
      r = $urandom_range(63);
      if (corners_bad(t, l, b, r) || rect_written(t, l, b, r)) begin
        push_query(t, l, b, r);
      end else begin
        push_bad_query();
      end
    end else begin
      for (tries = 0; tries < 40 && !done; tries++) begin
        t = $urandom_range(gen_rows - 1);
        l = $urandom_range(gen_cols - 1);
        if ($urandom_range(1)) begin
          b = $urandom_range(gen_rows - 1, t);
          r = $urandom_range(gen_cols - 1, l);
        end else begin
          b = t + $urandom_range(3);
          r = l + $urandom_range(3);
          if (b >= gen_rows) b = gen_rows - 1;
          if (r >= gen_cols) r = gen_cols - 1;
        end
        if ($urandom_range(9) == 0) begin
          t = 0;
          l = 0;
          b = gen_rows - 1;
          r = gen_cols - 1;
        end
        if (rect_written(t, l, b, r)) begin
          push_query(t, l, b, r);
          done = 1'b1;
        end
      end
      if (!done) push_bad_query();
    end
  endtask

  // Wait until the block has nothing left in flight
  task automatic wait_drained();
    while (grid_ops_q.size() != 0 || op_if.valid || awaited_counts.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [gaprc_pkg::GRID_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gaprc_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= gaprc_pkg::APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Resize the grid; every register write restarts loading at the origin
  task automatic set_grid(input logic [gaprc_pkg::GRID_W-1:0] rows_val, cols_val);
    write_reg(gaprc_pkg::REG_GRID_ROWS, rows_val);
    write_reg(gaprc_pkg::REG_GRID_COLS, cols_val);
    rows_m    = clamp_dim(rows_val, gaprc_pkg::MAX_ROWS);
    cols_m    = clamp_dim(cols_val, gaprc_pkg::MAX_COLS);
    ld_row    = 0;
    ld_col    = 0;
    run_pairs = 0;
    gen_rows  = rows_m;
    gen_cols  = cols_m;
    gen_row   = 0;
    gen_col   = 0;
  endtask

  task automatic run_phase(input logic [gaprc_pkg::GRID_W-1:0] rows_val, cols_val,
                           input int preload, input int mixed);
    wait_drained();
    set_grid(rows_val, cols_val);
    repeat (preload) push_load($urandom_range(99) < 75);
    repeat (mixed) begin
      if ($urandom_range(99) < 30) push_load($urandom_range(99) < 75);
      else push_random_query();
    end
  endtask

  // Driver: hold the transaction until taken, then offer the next or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!op_if.valid || op_if.ready) begin
        if (grid_ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_op          = grid_ops_q[0];
          grid_ops_q.delete(0);
          op_if.valid      <= 1'b1;
          op_if.mode       <= next_op.mode;
          op_if.cell_free  <= next_op.cell_free;
          op_if.top_row    <= next_op.top_row;
          op_if.left_col   <= next_op.left_col;
          op_if.bottom_row <= next_op.bottom_row;
          op_if.right_col  <= next_op.right_col;
        end else begin
          op_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= take_idle_pct());
    end
  end

  // Monitor: check results first, then predict from the accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (awaited_counts.size() == 0) begin
          note_failure($sformatf("result %0d with no query pending: count=%0d bad=%0b",
                                 results_seen, res_if.pair_count, res_if.bad_query));
        end else begin
          want = awaited_counts[0];
          awaited_counts.delete(0);
          if (res_if.pair_count !== want.pair_count || res_if.bad_query !== want.bad_query)
            note_failure($sformatf(
              "result %0d: expected count=%0d bad=%0b, got count=%0d bad=%0b",
              results_seen, want.pair_count, want.bad_query,
              res_if.pair_count, res_if.bad_query));
        end
      end
      if (op_if.valid && op_if.ready) begin
        ops_taken++;
        seen_op.mode       = op_if.mode;
        seen_op.cell_free  = op_if.cell_free;
        seen_op.top_row    = op_if.top_row;
        seen_op.left_col   = op_if.left_col;
        seen_op.bottom_row = op_if.bottom_row;
        seen_op.right_col  = op_if.right_col;
        if (seen_op.mode == gaprc_pkg::MODE_LOAD) predict_load(seen_op.cell_free);
        else awaited_counts = {awaited_counts, predict_query(seen_op)};
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)
          || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    op_if.valid      = 1'b0;
    op_if.mode       = gaprc_pkg::MODE_LOAD;
    op_if.cell_free  = 1'b0;
    op_if.top_row    = '0;
    op_if.left_col   = '0;
    op_if.bottom_row = '0;
    op_if.right_col  = '0;
    res_if.ready     = 1'b0;
    ops_taken        = 0;
    results_seen     = 0;
    err_cnt          = 0;
    quiet_cycles     = 0;
    rows_m           = gaprc_pkg::MAX_ROWS;
    cols_m           = gaprc_pkg::MAX_COLS;
    ld_row           = 0;
    ld_col           = 0;
    run_pairs        = 0;
    gen_rows         = gaprc_pkg::MAX_ROWS;
    gen_cols         = gaprc_pkg::MAX_COLS;
    gen_row          = 0;
    gen_col          = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero sizes clamp to a single cell; the grid wraps on every load
    set_grid(7'd0, 7'd0);
    push_load(1'b1);
    push_query(0, 0, 0, 0);
    push_query(0, 0, 1, 0);
    push_query(0, 0, 0, 1);
    push_load(1'b0);

    // Small grid with one blocked cell, then corner cases
    wait_drained();
    set_grid(7'd3, 7'd4);
    for (int i = 0; i < 12; i++) push_load(i != 6);
    push_query(0, 0, 2, 3);
    push_query(1, 1, 2, 2);
    push_query(2, 0, 0, 3);
    push_query(0, 3, 2, 0);
    push_query(63, 63, 63, 63);
    push_query(0, 0, 2, 4);
    // Overwrite the origin after wrap; the rest of the row stays stale
    push_load(1'b1);
    push_query(0, 0, 0, 1);

    // Random phases over several shapes, oversized values clamp to the maximum
    run_phase(7'd127, 7'd3,   192, 100);
    run_phase(7'd2,   7'd64,  128, 150);
    run_phase(7'd5,   7'd7,   35,  150);
    run_phase(7'd64,  7'd64,  256, 50);
    run_phase(7'd100, 7'd1,   64,  100);
    run_phase(7'd1,   7'd64,  64,  100);
    run_phase(7'd9,   7'd13,  117, 120);

    wait_drained();
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
